@@ rtl/core/gregorian_day_difference_unit_macros.svh @@
// Assertion macros for the Gregorian day difference unit.
`ifndef GREGORIAN_DAY_DIFFERENCE_UNIT_MACROS_SVH
`define GREGORIAN_DAY_DIFFERENCE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent holds, consequent must hold in the same cycle.
`define GDDU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gddu implication check failed");

// Antecedent holds, consequent must hold in the next cycle.
`define GDDU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gddu next-cycle check failed");

`else

`define GDDU_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define GDDU_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/gddu_pkg.sv @@
// Shared types, constants and calendar tables for the day difference unit.
package gddu_pkg;

   // Field widths
   localparam int DayWidth   = 5;
   localparam int MonthWidth = 4;
   localparam int YearWidth  = 14;
   localparam int NumWidth   = 23;
   localparam int GapWidth   = 22;
   localparam int OrderWidth = 2;

   // Reciprocal constants for division by 100 and by 400 of 15-bit values
   localparam int Recip100 = 20972;
   localparam int Shift100 = 21;
   localparam int Recip400 = 20972;
   localparam int Shift400 = 23;

   localparam logic [GapWidth-1:0] GapMax = {GapWidth{1'b1}};

   // Order codes
   localparam logic [OrderWidth-1:0] ORDER_SAME    = 2'b00;
   localparam logic [OrderWidth-1:0] ORDER_LATER   = 2'b01;
   localparam logic [OrderWidth-1:0] ORDER_EARLIER = 2'b11;

   // Load enables for the three date stages
   typedef struct packed {
      logic load_s1;
      logic load_s2;
      logic load_s3;
   } pipe_ctl_type;

   // Days in the year before the first of the month (non-leap)
   function automatic logic [8:0] days_before(input logic [MonthWidth-1:0] month);
      logic [8:0] days;
      case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   // Length of the month, February stretched in a leap year
   function automatic logic [DayWidth-1:0] month_len(input logic [MonthWidth-1:0] month,
                                                     input logic leap);
      logic [DayWidth-1:0] len;
      case (month)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

@@ rtl/core/gregorian_day_difference_unit.sv @@
// Top level of the Gregorian day difference unit: handshake and stage control.
//
//   channel   ports                                 direction   payload
//   request   req_tvalid / req_tready / req_tdata   in          two dates, 48 bits
//   response  rsp_tvalid / rsp_tready / rsp_tdata   out         order and gap, 24 bits
//             rsp_tuser                                         bad_date flag
//
// One item per cycle sustained while rsp_tready stays high; each item passes the three date
// stages (quotients, leap and offset, day number sum) and one compare stage before
// rsp_tvalid rises.
// Reset clears the four stage valid bits; payload registers are not reset.
// Each stage loads when it is empty or its successor moves, so a stall on the
// response side fills bubbles first and holds every item in place without loss.
`include "gregorian_day_difference_unit_macros.svh"

module gregorian_day_difference_unit #(
   parameter int YEAR_LIMIT = 9999
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // first_day[4:0], first_month[8:5], first_year[22:9],
   // second_day[27:23], second_month[31:28], second_year[45:32], zero [47:46]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // order[1:0], day_gap[23:2]
   output logic [23:0] rsp_tdata,
   // bad_date[0]
   output logic        rsp_tuser
);

   localparam int Stages = 4;

   logic [Stages-1:0] valid_ff, valid_in, stage_ready;
   gddu_pkg::pipe_ctl_type ctl;

   logic [gddu_pkg::NumWidth-1:0]   first_num, second_num;
   logic                            first_ok, second_ok;
   logic [gddu_pkg::OrderWidth-1:0] order;
   logic [gddu_pkg::GapWidth-1:0]   day_gap;
   logic                            bad_date;

   // Stage k may load when empty or when stage k+1 moves on
   always_comb begin
      stage_ready[Stages-1] = !valid_ff[Stages-1] || rsp_tready;
      for (int k = Stages - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      valid_in[0] = stage_ready[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < Stages; k++) begin
         valid_in[k] = stage_ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.load_s1 = stage_ready[0];
   assign ctl.load_s2 = stage_ready[1];
   assign ctl.load_s3 = stage_ready[2];

   gddu_date_stage #(
      .YEAR_LIMIT (YEAR_LIMIT)
   ) u_first (
      .clock   (clock),
      .ctl     (ctl),
      .day     (req_tdata[4:0]),
      .month   (req_tdata[8:5]),
      .year    (req_tdata[22:9]),
      .day_num (first_num),
      .date_ok (first_ok)
   );

   gddu_date_stage #(
      .YEAR_LIMIT (YEAR_LIMIT)
   ) u_second (
      .clock   (clock),
      .ctl     (ctl),
      .day     (req_tdata[27:23]),
      .month   (req_tdata[31:28]),
      .year    (req_tdata[45:32]),
      .day_num (second_num),
      .date_ok (second_ok)
   );

   gddu_compare u_compare (
      .clock      (clock),
      .load       (stage_ready[3]),
      .first_num  (first_num),
      .second_num (second_num),
      .first_ok   (first_ok),
      .second_ok  (second_ok),
      .order      (order),
      .day_gap    (day_gap),
      .bad_date   (bad_date)
   );

   assign req_tready = stage_ready[0];
   assign rsp_tvalid = valid_ff[Stages-1];
   assign rsp_tdata  = {day_gap, order};
   assign rsp_tuser  = bad_date;

   // Checks
   `GDDU_ASSERT_IMPLY(a_bad_zero, clock, reset, rsp_tvalid && bad_date, (order == gddu_pkg::ORDER_SAME) && (day_gap == '0))
   `GDDU_ASSERT_IMPLY(a_same_no_gap, clock, reset, rsp_tvalid && (order == gddu_pkg::ORDER_SAME), day_gap == '0)
   `GDDU_ASSERT_IMPLY(a_order_gap, clock, reset, rsp_tvalid && (order != gddu_pkg::ORDER_SAME), day_gap != '0)
   `GDDU_ASSERT_IMPLY(a_order_code, clock, reset, rsp_tvalid, (order == gddu_pkg::ORDER_SAME) || (order == gddu_pkg::ORDER_LATER) || (order == gddu_pkg::ORDER_EARLIER))
   `GDDU_ASSERT_IMPLY(a_entry_source, clock, reset, $rose(valid_ff[0]), $past(req_tvalid && req_tready))
   `GDDU_ASSERT_NEXT(a_stage_hold, clock, reset, valid_ff[2] && !stage_ready[2], valid_ff[2])

endmodule

@@ rtl/core/gddu_date_stage.sv @@
// Three-stage day number and validity pipeline for one calendar date.
module gddu_date_stage #(
   parameter int YEAR_LIMIT = 9999
) (
   input  logic                                clock,
   input  gddu_pkg::pipe_ctl_type              ctl,
   input  logic [gddu_pkg::DayWidth-1:0]       day,
   input  logic [gddu_pkg::MonthWidth-1:0]     month,
   input  logic [gddu_pkg::YearWidth-1:0]      year,
   output logic [gddu_pkg::NumWidth-1:0]       day_num,
   output logic                                date_ok
);

   // Stage 1: quotients, year times 365, year range
   logic [14:0] y_p99, y_p399, y_wide;
   logic [29:0] prod_a, prod_b, prod_c;
   logic [gddu_pkg::NumWidth-1:0] y365_in;
   logic [7:0]  q100_in, qa_in;
   logic [5:0]  qb_in;
   logic [12:0] quad_in;
   logic        year_ok_in;

   logic [gddu_pkg::DayWidth-1:0]   s1_day_ff;
   logic [gddu_pkg::MonthWidth-1:0] s1_month_ff;
   logic [gddu_pkg::YearWidth-1:0]  s1_year_ff;
   logic [gddu_pkg::NumWidth-1:0]   s1_y365_ff;
   logic [7:0]  s1_q100_ff, s1_qa_ff;
   logic [5:0]  s1_qb_ff;
   logic [12:0] s1_quad_ff;
   logic        s1_year_ok_ff;

   always_comb begin
      y_wide     = 15'(year);
      y_p99      = y_wide + 15'd99;
      y_p399     = y_wide + 15'd399;
      prod_a     = 30'(y_wide) * 30'(gddu_pkg::Recip100);
      prod_b     = 30'(y_p99) * 30'(gddu_pkg::Recip100);
      prod_c     = 30'(y_p399) * 30'(gddu_pkg::Recip400);
      q100_in    = 8'(prod_a >> gddu_pkg::Shift100);
      qa_in      = 8'(prod_b >> gddu_pkg::Shift100);
      qb_in      = 6'(prod_c >> gddu_pkg::Shift400);
      quad_in    = 13'((y_wide + 15'd3) >> 2);
      y365_in    = gddu_pkg::NumWidth'(year) * gddu_pkg::NumWidth'(365);
      year_ok_in = (32'(year) <= 32'(YEAR_LIMIT));
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s1) begin
         s1_day_ff     <= day;
         s1_month_ff   <= month;
         s1_year_ff    <= year;
         s1_y365_ff    <= y365_in;
         s1_q100_ff    <= q100_in;
         s1_qa_ff      <= qa_in;
         s1_qb_ff      <= qb_in;
         s1_quad_ff    <= quad_in;
         s1_year_ok_ff <= year_ok_in;
      end
   end

   // Stage 2: leap rule, leap count, month offset, validity
   logic [14:0] prod100;
   logic        cent_in, leap_in, late_leap_in, ok_in;
   logic [12:0] leaps_in;
   logic [8:0]  offset_in;
   logic [gddu_pkg::DayWidth-1:0] len_in;

   logic [gddu_pkg::NumWidth-1:0] s2_y365_ff;
   logic [12:0] s2_leaps_ff;
   logic [8:0]  s2_offset_ff;
   logic [gddu_pkg::DayWidth-1:0] s2_day_ff;
   logic        s2_late_leap_ff, s2_ok_ff;

   always_comb begin
      prod100      = 15'(s1_q100_ff) * 15'd100;
      cent_in      = (15'(s1_year_ff) == prod100);
      leap_in      = (s1_year_ff[1:0] == 2'b00) && (!cent_in || (s1_q100_ff[1:0] == 2'b00));
      leaps_in     = s1_quad_ff - 13'(s1_qa_ff) + 13'(s1_qb_ff);
      offset_in    = gddu_pkg::days_before(s1_month_ff);
      len_in       = gddu_pkg::month_len(s1_month_ff, leap_in);
      late_leap_in = leap_in && (s1_month_ff > 4'd2);
      ok_in        = s1_year_ok_ff && (s1_month_ff inside {[4'd1:4'd12]}) &&
                     (s1_day_ff != 5'd0) && (s1_day_ff <= len_in);
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s2) begin
         s2_y365_ff      <= s1_y365_ff;
         s2_leaps_ff     <= leaps_in;
         s2_offset_ff    <= offset_in;
         s2_day_ff       <= s1_day_ff;
         s2_late_leap_ff <= late_leap_in;
         s2_ok_ff        <= ok_in;
      end
   end

   // Stage 3: sum the day number
   logic [gddu_pkg::NumWidth-1:0] num_in;
   logic [gddu_pkg::NumWidth-1:0] s3_num_ff;
   logic                          s3_ok_ff;

   assign num_in = s2_y365_ff + gddu_pkg::NumWidth'(s2_leaps_ff)
                 + gddu_pkg::NumWidth'(s2_offset_ff) + gddu_pkg::NumWidth'(s2_day_ff)
                 + gddu_pkg::NumWidth'(s2_late_leap_ff);

   always_ff @(posedge clock) begin
      if (ctl.load_s3) begin
         s3_num_ff <= num_in;
         s3_ok_ff  <= s2_ok_ff;
      end
   end

   assign day_num = s3_num_ff;
   assign date_ok = s3_ok_ff;

endmodule

@@ rtl/core/gddu_compare.sv @@
// Output stage: order, saturated day gap and error flag of two day numbers.
module gddu_compare (
   input  logic                                clock,
   input  logic                                load,
   input  logic [gddu_pkg::NumWidth-1:0]       first_num,
   input  logic [gddu_pkg::NumWidth-1:0]       second_num,
   input  logic                                first_ok,
   input  logic                                second_ok,
   output logic [gddu_pkg::OrderWidth-1:0]     order,
   output logic [gddu_pkg::GapWidth-1:0]       day_gap,
   output logic                                bad_date
);

   logic [gddu_pkg::NumWidth-1:0]   diff;
   logic [gddu_pkg::OrderWidth-1:0] order_in, order_ff;
   logic [gddu_pkg::GapWidth-1:0]   gap_in, gap_ff;
   logic                            bad_in, bad_ff;

   // Compare, subtract the smaller, clamp, zero on error
   always_comb begin
      bad_in   = !(first_ok && second_ok);
      diff     = '0;
      order_in = gddu_pkg::ORDER_SAME;
      if (first_num > second_num) begin
         diff     = first_num - second_num;
         order_in = gddu_pkg::ORDER_LATER;
      end else if (first_num < second_num) begin
         diff     = second_num - first_num;
         order_in = gddu_pkg::ORDER_EARLIER;
      end
      if (diff > gddu_pkg::NumWidth'(gddu_pkg::GapMax)) begin
         gap_in = gddu_pkg::GapMax;
      end else begin
         gap_in = diff[gddu_pkg::GapWidth-1:0];
      end
      if (bad_in) begin
         order_in = gddu_pkg::ORDER_SAME;
         gap_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         order_ff <= order_in;
         gap_ff   <= gap_in;
         bad_ff   <= bad_in;
      end
   end

   assign order    = order_ff;
   assign day_gap  = gap_ff;
   assign bad_date = bad_ff;

endmodule
